>>> rtl/dlle_pkg.sv
package dlle_pkg;

  localparam int unsigned CAPACITY_DEF   = 64;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  localparam logic [2:0] OP_APPEND     = 3'd0;
  localparam logic [2:0] OP_PREPEND    = 3'd1;
  localparam logic [2:0] OP_DROP_LAST  = 3'd2;
  localparam logic [2:0] OP_DROP_FIRST = 3'd3;
  localparam logic [2:0] OP_INSERT     = 3'd4;
  localparam logic [2:0] OP_ERASE      = 3'd5;
  localparam logic [2:0] OP_READ       = 3'd6;
  localparam logic [2:0] OP_WRITE      = 3'd7;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

endpackage

>>> rtl/dlle_node_mem.sv
// Node pool: data, forward and backward stores, one access per cycle each.
module dlle_node_mem #(
  parameter int unsigned CAPACITY   = dlle_pkg::CAPACITY_DEF,
  parameter int unsigned DATA_WIDTH = dlle_pkg::DATA_WIDTH_DEF,
  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic                  clk,
  input  logic                  d_we,
  input  logic [AW-1:0]         d_addr,
  input  logic [DATA_WIDTH-1:0] d_wdata,
  output logic [DATA_WIDTH-1:0] d_rdata,
  input  logic                  f_we,
  input  logic [AW-1:0]         f_addr,
  input  logic [AW:0]           f_wdata,
  output logic [AW:0]           f_rdata,
  input  logic                  b_we,
  input  logic [AW-1:0]         b_addr,
  input  logic [AW-1:0]         b_wdata,
  output logic [AW-1:0]         b_rdata
);

  logic [DATA_WIDTH-1:0] data_mem [CAPACITY];
  // forward link holds one extra bit so a free-stack link can mean "none"
  logic [AW:0]           fwd_mem  [CAPACITY];
  logic [AW-1:0]         bwd_mem  [CAPACITY];

  always_ff @(posedge clk) begin
    if (d_we) begin
      data_mem[d_addr] <= d_wdata;
    end
    d_rdata <= data_mem[d_addr];
  end

  always_ff @(posedge clk) begin
    if (f_we) begin
      fwd_mem[f_addr] <= f_wdata;
    end
    f_rdata <= fwd_mem[f_addr];
  end

  always_ff @(posedge clk) begin
    if (b_we) begin
      bwd_mem[b_addr] <= b_wdata;
    end
    b_rdata <= bwd_mem[b_addr];
  end

endmodule

>>> rtl/doubly_linked_list_engine_core.sv
// Channel | Ports                                              | Direction
// in      | in_valid in_stall in_operation in_position in_value | into block
// out     | out_valid out_stall out_status out_read_value       | out of block
//         | out_element_total out_is_empty out_front_value      |
//         | out_back_value                                      |
// One item at a time. Failed ops go straight to the result state; pushes and end
// inserts take a node, off the free stack or from the unused pool, then link it.
// Pops unlink the end node and fetch any new end value. Positional ops walk one
// forward link per cycle from the front to the position, then read, write, erase or link.
// The next transfer is taken back in idle, after the result is registered; a stalled
// result only holds the following item in its last state. Sync active-low reset
// clears control; node memories are not cleared.
module doubly_linked_list_engine_core #(
  parameter int unsigned CAPACITY   = dlle_pkg::CAPACITY_DEF,
  parameter int unsigned DATA_WIDTH = dlle_pkg::DATA_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_operation,
  input  logic [6:0]  in_position,
  input  logic [31:0] in_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [31:0] out_read_value,
  output logic [6:0]  out_element_total,
  output logic        out_is_empty,
  output logic [31:0] out_front_value,
  output logic [31:0] out_back_value
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = AW + 1;
  localparam int unsigned XW = (CW > 7) ? CW : 7;
  localparam logic [CW-1:0] CAP = CW'(CAPACITY);

  typedef enum logic [3:0] {
    S_IDLE, S_WALK0, S_WALK, S_TGT_RD, S_TGT, S_UNL, S_RELINK, S_NEW_FRONT,
    S_NEW_BACK, S_TAKE, S_TAKE_W, S_LINK, S_FIX_F, S_FIX_B, S_DONE
  } state_t;

  state_t state_r;

  logic [2:0]            op_r;
  logic [CW-1:0]         pos_r;
  logic [DATA_WIDTH-1:0] val_r;
  logic [CW-1:0]         cnt_r;
  logic [AW-1:0]         first_r, last_r;
  logic [CW-1:0]         free_top_r, fill_r;
  logic [CW-1:0]         walk_i_r;
  logic [AW-1:0]         cur_r, new_r, prev_r, next_r;
  logic [1:0]            st_r;
  logic [DATA_WIDTH-1:0] rd_r;
  logic                  link_mid_r, link_back_r;
  logic [DATA_WIDTH-1:0] front_r, back_r;

  logic                  d_we, f_we, b_we;
  logic [AW-1:0]         d_addr, f_addr, b_addr;
  logic [DATA_WIDTH-1:0] d_wdata, d_rdata;
  logic [CW-1:0]         f_wdata, f_rdata;
  logic [AW-1:0]         b_wdata, b_rdata;

  logic ov_r;
  logic ov_nxt;
  logic done_fire;
  logic [1:0] o_st_r;
  logic [31:0] o_rd_r, o_fr_r, o_bk_r;
  logic [6:0] o_cnt_r;

  logic [AW-1:0]          walk_node;
  logic [CW-1:0]          walk_nxt;
  logic [XW-1:0]          pos_x, cnt_x;
  logic [DATA_WIDTH+31:0] in_val_ext;

  dlle_node_mem #(.CAPACITY(CAPACITY), .DATA_WIDTH(DATA_WIDTH)) u_mem (
    .clk(clk),
    .d_we(d_we), .d_addr(d_addr), .d_wdata(d_wdata), .d_rdata(d_rdata),
    .f_we(f_we), .f_addr(f_addr), .f_wdata(f_wdata), .f_rdata(f_rdata),
    .b_we(b_we), .b_addr(b_addr), .b_wdata(b_wdata), .b_rdata(b_rdata)
  );

  function automatic logic [AW-1:0] ixf(input logic [CW-1:0] s);
    ixf = (s < CAP) ? s[AW-1:0] : '0;
  endfunction

  function automatic logic [31:0] to32(input logic [DATA_WIDTH-1:0] d);
    logic [DATA_WIDTH+31:0] w;
    w = {32'd0, d};
    to32 = w[31:0];
  endfunction

  assign in_stall = (state_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_status = o_st_r;
  assign out_read_value = o_rd_r;
  assign out_element_total = o_cnt_r;
  assign out_is_empty = (o_cnt_r == 7'd0);
  assign out_front_value = o_fr_r;
  assign out_back_value = o_bk_r;

  assign in_val_ext = {{DATA_WIDTH{1'b0}}, in_value};
  assign walk_node = ixf(f_rdata);
  assign walk_nxt = walk_i_r + 1'b1;
  assign pos_x = XW'(in_position);
  assign cnt_x = XW'(cnt_r);

  assign done_fire = (state_r == S_DONE) && (!ov_r || !out_stall);
  assign ov_nxt = done_fire || (ov_r && out_stall);

  // memory port control
  always_comb begin
    d_we = 1'b0; f_we = 1'b0; b_we = 1'b0;
    d_addr = cur_r; f_addr = cur_r; b_addr = cur_r;
    d_wdata = val_r; f_wdata = '0; b_wdata = '0;
    case (state_r)
      S_WALK: begin
        // next address comes straight from the forward link just read
        d_addr = walk_node; f_addr = walk_node; b_addr = walk_node;
      end
      S_TGT: begin
        d_we = (op_r == dlle_pkg::OP_WRITE);
      end
      S_UNL: begin
        // push freed node onto free stack, fetch the new end value
        f_we = 1'b1; f_wdata = free_top_r;
        d_addr = (cur_r == first_r) ? next_r : prev_r;
      end
      S_RELINK: begin
        f_we = 1'b1; f_addr = prev_r; f_wdata = {1'b0, next_r};
        b_we = 1'b1; b_addr = next_r; b_wdata = prev_r;
      end
      S_TAKE: begin
        f_addr = free_top_r[AW-1:0];
      end
      S_LINK: begin
        d_we = 1'b1; d_addr = new_r;
        f_we = 1'b1; f_addr = new_r;
        b_we = 1'b1; b_addr = new_r;
        if (link_mid_r) begin
          f_wdata = {1'b0, next_r}; b_wdata = prev_r;
        end else if (link_back_r) begin
          f_wdata = '0; b_wdata = last_r;
        end else begin
          f_wdata = {1'b0, first_r}; b_wdata = '0;
        end
      end
      S_FIX_F: begin
        f_we = 1'b1; f_addr = prev_r; f_wdata = {1'b0, new_r};
      end
      S_FIX_B: begin
        b_we = 1'b1; b_addr = next_r; b_wdata = new_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0; first_r <= '0; last_r <= '0;
      free_top_r <= CAP; fill_r <= '0;
      front_r <= '0; back_r <= '0;
      ov_r <= 1'b0;
      o_st_r <= dlle_pkg::ST_OK; o_rd_r <= '0; o_cnt_r <= '0;
      o_fr_r <= '0; o_bk_r <= '0;
    end else begin
      ov_r <= ov_nxt;
      case (state_r)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            op_r <= in_operation;
            pos_r <= CW'(in_position);
            val_r <= in_val_ext[DATA_WIDTH-1:0];
            rd_r <= '0;
            walk_i_r <= '0;
            case (in_operation)
              dlle_pkg::OP_APPEND, dlle_pkg::OP_PREPEND: begin
                link_mid_r <= 1'b0;
                link_back_r <= (in_operation == dlle_pkg::OP_APPEND);
                cur_r <= first_r;
                if (cnt_r >= CAP) begin
                  st_r <= dlle_pkg::ST_FULL; state_r <= S_DONE;
                end else begin
                  st_r <= dlle_pkg::ST_OK; state_r <= S_TAKE;
                end
              end
              dlle_pkg::OP_DROP_LAST, dlle_pkg::OP_DROP_FIRST: begin
                link_mid_r <= 1'b0; link_back_r <= 1'b0;
                cur_r <= (in_operation == dlle_pkg::OP_DROP_LAST) ? last_r : first_r;
                if (cnt_r == '0) begin
                  st_r <= dlle_pkg::ST_EMPTY; state_r <= S_DONE;
                end else begin
                  st_r <= dlle_pkg::ST_OK; state_r <= S_TGT_RD;
                end
              end
              dlle_pkg::OP_INSERT: begin
                cur_r <= first_r;
                if (cnt_r >= CAP) begin
                  link_mid_r <= 1'b0; link_back_r <= 1'b0;
                  st_r <= dlle_pkg::ST_FULL; state_r <= S_DONE;
                end else if (pos_x > cnt_x) begin
                  link_mid_r <= 1'b0; link_back_r <= 1'b0;
                  st_r <= dlle_pkg::ST_RANGE; state_r <= S_DONE;
                end else if (in_position == 7'd0) begin
                  link_mid_r <= 1'b0; link_back_r <= 1'b0;
                  st_r <= dlle_pkg::ST_OK; state_r <= S_TAKE;
                end else if (pos_x == cnt_x) begin
                  link_mid_r <= 1'b0; link_back_r <= 1'b1;
                  st_r <= dlle_pkg::ST_OK; state_r <= S_TAKE;
                end else begin
                  link_mid_r <= 1'b1; link_back_r <= 1'b0;
                  st_r <= dlle_pkg::ST_OK; state_r <= S_WALK0;
                end
              end
              default: begin
                link_mid_r <= 1'b0; link_back_r <= 1'b0;
                cur_r <= first_r;
                if (cnt_r == '0) begin
                  st_r <= dlle_pkg::ST_EMPTY; state_r <= S_DONE;
                end else if (pos_x >= cnt_x) begin
                  st_r <= dlle_pkg::ST_RANGE; state_r <= S_DONE;
                end else if (in_position == 7'd0) begin
                  st_r <= dlle_pkg::ST_OK; state_r <= S_TGT_RD;
                end else begin
                  st_r <= dlle_pkg::ST_OK; state_r <= S_WALK0;
                end
              end
            endcase
          end
        end
        S_WALK0: begin
          state_r <= S_WALK;
        end
        S_WALK: begin
          if (walk_nxt == pos_r) begin
            cur_r <= walk_node;
            state_r <= S_TGT;
          end else begin
            walk_i_r <= walk_nxt;
          end
        end
        S_TGT_RD: begin
          state_r <= S_TGT;
        end
        S_TGT: begin
          case (op_r)
            dlle_pkg::OP_READ: begin
              rd_r <= d_rdata;
              state_r <= S_DONE;
            end
            dlle_pkg::OP_WRITE: begin
              if (cur_r == first_r) front_r <= val_r;
              if (cur_r == last_r) back_r <= val_r;
              state_r <= S_DONE;
            end
            dlle_pkg::OP_INSERT: begin
              prev_r <= b_rdata;
              next_r <= cur_r;
              state_r <= S_TAKE;
            end
            default: begin
              prev_r <= b_rdata;
              next_r <= ixf(f_rdata);
              state_r <= S_UNL;
            end
          endcase
        end
        S_UNL: begin
          cnt_r <= cnt_r - 1'b1;
          free_top_r <= {1'b0, cur_r};
          if (cur_r == first_r && cur_r == last_r) begin
            first_r <= '0; last_r <= '0;
            front_r <= '0; back_r <= '0;
            state_r <= S_DONE;
          end else if (cur_r == first_r) begin
            first_r <= next_r;
            state_r <= S_NEW_FRONT;
          end else if (cur_r == last_r) begin
            last_r <= prev_r;
            state_r <= S_NEW_BACK;
          end else begin
            state_r <= S_RELINK;
          end
        end
        S_RELINK: begin
          state_r <= S_DONE;
        end
        S_NEW_FRONT: begin
          front_r <= d_rdata;
          state_r <= S_DONE;
        end
        S_NEW_BACK: begin
          back_r <= d_rdata;
          state_r <= S_DONE;
        end
        S_TAKE: begin
          if (free_top_r < CAP) begin
            new_r <= free_top_r[AW-1:0];
            state_r <= S_TAKE_W;
          end else begin
            new_r <= ixf(fill_r);
            fill_r <= fill_r + 1'b1;
            state_r <= S_LINK;
          end
        end
        S_TAKE_W: begin
          free_top_r <= f_rdata;
          state_r <= S_LINK;
        end
        S_LINK: begin
          cnt_r <= cnt_r + 1'b1;
          if (link_mid_r) begin
            state_r <= S_FIX_F;
          end else if (link_back_r) begin
            last_r <= new_r; back_r <= val_r;
            if (cnt_r == '0) begin
              first_r <= new_r; front_r <= val_r;
              state_r <= S_DONE;
            end else begin
              prev_r <= last_r;
              state_r <= S_FIX_F;
            end
          end else begin
            first_r <= new_r; front_r <= val_r;
            if (cnt_r == '0) begin
              last_r <= new_r; back_r <= val_r;
              state_r <= S_DONE;
            end else begin
              next_r <= first_r;
              state_r <= S_FIX_B;
            end
          end
        end
        S_FIX_F: begin
          state_r <= link_mid_r ? S_FIX_B : S_DONE;
        end
        S_FIX_B: begin
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (done_fire) begin
            o_st_r <= st_r;
            o_rd_r <= to32(rd_r);
            o_cnt_r <= 7'(cnt_r);
            o_fr_r <= to32(front_r);
            o_bk_r <= to32(back_r);
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

>>> dv/tb_doubly_linked_list_engine_core.sv
module tb_doubly_linked_list_engine_core;

  localparam int CAP = dlle_pkg::CAPACITY_DEF;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] rd;
    logic [6:0]  total;
    logic        empty;
    logic [31:0] front;
    logic [31:0] back;
  } list_resp_t;

  typedef struct {
    logic [2:0]  op;
    logic [6:0]  pos;
    logic [31:0] val;
    bit          has_exp;
    logic [1:0]  st;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_operation = '0;
  logic [6:0]  in_position = '0;
  logic [31:0] in_value = '0;
  logic        out_valid;
  logic        out_stall = 1'b1;
  logic [1:0]  out_status;
  logic [31:0] out_read_value;
  logic [6:0]  out_element_total;
  logic        out_is_empty;
  logic [31:0] out_front_value;
  logic [31:0] out_back_value;

  always #1 clk = ~clk;

  doubly_linked_list_engine_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_operation(in_operation), .in_position(in_position), .in_value(in_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_read_value(out_read_value),
    .out_element_total(out_element_total), .out_is_empty(out_is_empty),
    .out_front_value(out_front_value), .out_back_value(out_back_value)
  );

  // shadow list kept as a plain ordered array
  logic [31:0] shadow_list[$];
  list_resp_t  pending_resp[$];
  int          mismatches = 0;

  function automatic list_resp_t apply_list_op(logic [2:0] op, logic [6:0] pos,
                                               logic [31:0] val);
    list_resp_t r;
    int n;
    r = '0;
    r.status = dlle_pkg::ST_OK;
    n = shadow_list.size();
    case (op)
      dlle_pkg::OP_APPEND, dlle_pkg::OP_PREPEND: begin
        if (n >= CAP) r.status = dlle_pkg::ST_FULL;
        else if (op == dlle_pkg::OP_APPEND) shadow_list.insert(n, val);
        else shadow_list.insert(0, val);
      end
      dlle_pkg::OP_DROP_LAST, dlle_pkg::OP_DROP_FIRST: begin
        if (n == 0) r.status = dlle_pkg::ST_EMPTY;
        else if (op == dlle_pkg::OP_DROP_LAST) shadow_list.delete(n - 1);
        else shadow_list.delete(0);
      end
      dlle_pkg::OP_INSERT: begin
        if (n >= CAP) r.status = dlle_pkg::ST_FULL;
        else if (pos > n) r.status = dlle_pkg::ST_RANGE;
        else shadow_list.insert(pos, val);
      end
      default: begin
        if (n == 0) r.status = dlle_pkg::ST_EMPTY;
        else if (pos >= n) r.status = dlle_pkg::ST_RANGE;
        else if (op == dlle_pkg::OP_ERASE) shadow_list.delete(pos);
        else if (op == dlle_pkg::OP_READ) r.rd = shadow_list[pos];
        else shadow_list[pos] = val;
      end
    endcase
    n = shadow_list.size();
    r.total = n[6:0];
    r.empty = (n == 0);
    if (n != 0) begin
      r.front = shadow_list[0];
      r.back = shadow_list[n-1];
    end
    return r;
  endfunction

  task automatic send_op(logic [2:0] op, logic [6:0] pos, logic [31:0] val,
                         bit has_exp, logic [1:0] st);
    list_resp_t r;
    int idle;
    idle = $urandom_range(0, 4);
    if (idle != 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(negedge clk);
    end
    r = apply_list_op(op, pos, val);
    if (has_exp && r.status != st) begin
      mismatches++;
      if (mismatches <= 10)
        $display("directed status: op %0d pos %0d exp %0d model %0d",
                 op, pos, st, r.status);
    end
    pending_resp.insert(pending_resp.size(), r);
    in_operation <= op;
    in_position <= pos;
    in_value <= val;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // result checker and random backpressure
  initial begin : drain
    int wait_cyc;
    list_resp_t got, exp;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      wait_cyc = $urandom_range(0, 4);
      if ($urandom_range(0, 9) < 3) wait_cyc = 0;
      out_stall <= (wait_cyc != 0);
      if (wait_cyc != 0) begin
        repeat (wait_cyc) @(negedge clk);
        out_stall <= 1'b0;
      end
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      got = '{out_status, out_read_value, out_element_total, out_is_empty,
              out_front_value, out_back_value};
      if (pending_resp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer %h", got);
      end else begin
        exp = pending_resp[0];
        pending_resp.delete(0);
        if (got !== exp) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp st=%0d rd=%h n=%0d e=%0b f=%h b=%h",
                      " got st=%0d rd=%h n=%0d e=%0b f=%h b=%h"},
                     exp.status, exp.rd, exp.total, exp.empty, exp.front, exp.back,
                     got.status, got.rd, got.total, got.empty, got.front, got.back);
        end
      end
    end
  end

  initial begin : stim
    dir_row_t dir_rows[$];
    int k, n, sel;
    logic [2:0] op;
    logic [6:0] pos;
    dir_rows = '{
      '{dlle_pkg::OP_DROP_LAST,  7'd0,   32'h0,        1, dlle_pkg::ST_EMPTY},
      '{dlle_pkg::OP_DROP_FIRST, 7'd0,   32'h0,        1, dlle_pkg::ST_EMPTY},
      '{dlle_pkg::OP_ERASE,      7'd0,   32'h0,        1, dlle_pkg::ST_EMPTY},
      '{dlle_pkg::OP_READ,       7'd0,   32'h0,        1, dlle_pkg::ST_EMPTY},
      '{dlle_pkg::OP_WRITE,      7'd0,   32'h1,        1, dlle_pkg::ST_EMPTY},
      '{dlle_pkg::OP_INSERT,     7'd1,   32'h5,        1, dlle_pkg::ST_RANGE},
      '{dlle_pkg::OP_INSERT,     7'd0,   32'hFFFFFFFF, 1, dlle_pkg::ST_OK},
      '{dlle_pkg::OP_APPEND,     7'd0,   32'h0,        1, dlle_pkg::ST_OK},
      '{dlle_pkg::OP_PREPEND,    7'd0,   32'hA5A5A5A5, 1, dlle_pkg::ST_OK},
      '{dlle_pkg::OP_INSERT,     7'd3,   32'h5A5A5A5A, 1, dlle_pkg::ST_OK},
      '{dlle_pkg::OP_INSERT,     7'd2,   32'h12345678, 1, dlle_pkg::ST_OK},
      '{dlle_pkg::OP_READ,       7'd2,   32'h0,        0, dlle_pkg::ST_OK},
      '{dlle_pkg::OP_READ,       7'd5,   32'h0,        1, dlle_pkg::ST_RANGE},
      '{dlle_pkg::OP_READ,       7'd127, 32'h0,        1, dlle_pkg::ST_RANGE},
      '{dlle_pkg::OP_WRITE,      7'd4,   32'hDEADBEEF, 1, dlle_pkg::ST_OK},
      '{dlle_pkg::OP_WRITE,      7'd5,   32'h1,        1, dlle_pkg::ST_RANGE},
      '{dlle_pkg::OP_ERASE,      7'd2,   32'h0,        1, dlle_pkg::ST_OK},
      '{dlle_pkg::OP_ERASE,      7'd4,   32'h0,        1, dlle_pkg::ST_RANGE},
      '{dlle_pkg::OP_ERASE,      7'd3,   32'h0,        1, dlle_pkg::ST_OK},
      '{dlle_pkg::OP_DROP_LAST,  7'd0,   32'h0,        1, dlle_pkg::ST_OK},
      '{dlle_pkg::OP_DROP_FIRST, 7'd0,   32'h0,        1, dlle_pkg::ST_OK},
      '{dlle_pkg::OP_READ,       7'd0,   32'h0,        0, dlle_pkg::ST_OK},
      '{dlle_pkg::OP_ERASE,      7'd0,   32'h0,        1, dlle_pkg::ST_OK},
      '{dlle_pkg::OP_READ,       7'd0,   32'h0,        1, dlle_pkg::ST_EMPTY}
    };
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    foreach (dir_rows[i])
      send_op(dir_rows[i].op, dir_rows[i].pos, dir_rows[i].val,
              dir_rows[i].has_exp, dir_rows[i].st);
    // fill to capacity, check full on both push and insert, then drain
    for (k = 0; k < CAP; k++)
      send_op(dlle_pkg::OP_APPEND, 7'd0, $urandom, 0, dlle_pkg::ST_OK);
    send_op(dlle_pkg::OP_PREPEND, 7'd0, 32'h1, 1, dlle_pkg::ST_FULL);
    send_op(dlle_pkg::OP_INSERT, 7'd64, 32'h1, 1, dlle_pkg::ST_FULL);
    send_op(dlle_pkg::OP_READ, 7'd63, 32'h0, 1, dlle_pkg::ST_OK);
    send_op(dlle_pkg::OP_WRITE, 7'd64, 32'h0, 1, dlle_pkg::ST_RANGE);
    for (k = 0; k < CAP; k++)
      send_op(dlle_pkg::OP_DROP_FIRST, 7'd0, 32'h0, 1, dlle_pkg::ST_OK);
    // random part: bias ops toward the current size so the list wanders widely
    for (k = 0; k < 1640; k++) begin
      n = shadow_list.size();
      sel = $urandom_range(0, 99);
      if (sel < 30) op = (n < 48 || $urandom_range(0, 1)) ?
                         3'($urandom_range(0, 1)) : dlle_pkg::OP_DROP_LAST;
      else if (sel < 45) op = dlle_pkg::OP_INSERT;
      else op = 3'($urandom_range(2, 7));
      if ((k / 300) % 2 == 1 && sel < 40) op = dlle_pkg::OP_APPEND;
      if ($urandom_range(0, 19) == 0) pos = 7'($urandom);
      else if ($urandom_range(0, 9) == 0) pos = 7'(n);
      else pos = 7'($urandom_range(0, n));
      send_op(op, pos, $urandom, 0, dlle_pkg::ST_OK);
    end
    in_valid <= 1'b0;
    while (pending_resp.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && pending_resp.size() == 0)
      $display("tb_doubly_linked_list_engine_core: PASS");
    else
      $display("tb_doubly_linked_list_engine_core: FAIL");
    $finish;
  end

  initial begin : watchdog
    #4000000;
    $display("tb_doubly_linked_list_engine_core: FAIL");
    $finish;
  end

endmodule
